>>> rtl/core/bfsa_pkg.sv
// Shared types and constants for the best-fit segment allocator.
package bfsa_pkg;

    localparam int MAX_SEG   = 64;
    localparam int IDX_W     = $clog2(MAX_SEG);
    localparam int CNT_W     = $clog2(MAX_SEG + 1);
    localparam int OWN_W     = 8;
    localparam int LEN_W     = 16;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 24;
    localparam logic [LEN_W-1:0] TOTAL_RST = 16'd1024;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OWNER = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    typedef struct packed {
        logic [OWN_W-1:0] owner;
        logic             used;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] start;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

endpackage

>>> rtl/core/bfsa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module bfsa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/best_fit_segment_allocator.sv
// Top level: segment table sequencer around one segment RAM.
//
//  channel   | direction | contents
//  s_axis    | in        | tuser: func; tdata: owner_id, request_size
//  m_axis    | out       | tdata: status, block_start
//  cfg       | in        | total_size write, reinitializes the table
//
// Each request scans the table through the RAM read port, one entry a cycle,
// then decides in S_DEC. A split shifts the entries above the chosen one up, a
// merge shifts the entries above it down, one entry a cycle; S_WR1 writes the
// allocated entry and, on a split, S_WR2 the leftover free entry, while on release
// S_RWR writes the merged entry before the shift. S_DONE loads the result, then the
// sequencer returns to idle. After reset or a total_size write S_INIT rebuilds
// entry 0; no request is taken then. A result waits in the output register while
// the next runs; a later result stalls until that register drains.
module best_fit_segment_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bfsa_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bfsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // owner_id[7:0], request_size[23:8]
    input  logic                             s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bfsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // status[1:0], block_start[17:2]
);
    import bfsa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_DEC, S_SHUP, S_WR1, S_WR2, S_RWR, S_SHDN, S_DONE
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_total;
    logic [CNT_W-1:0] r_count;
    logic             r_func;
    logic [OWN_W-1:0] r_owner;
    logic [LEN_W-1:0] r_size;

    logic [CNT_W-1:0] r_ptr;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;

    logic             r_fnd;
    logic [IDX_W-1:0] r_fidx;
    t_seg             r_fent;
    t_seg             r_prev;
    t_seg             r_last;
    t_seg             r_next;
    logic             r_nxt_pend;
    logic             r_has_next;

    logic             r_bv;
    logic [IDX_W-1:0] r_bidx;
    logic [LEN_W-1:0] r_bleft;
    logic [LEN_W-1:0] r_bstart;
    logic             r_split;

    logic [IDX_W-1:0] r_wa;
    t_seg             r_wd;
    logic [1:0]       r_k;

    logic [1:0]       r_res_status;
    logic [LEN_W-1:0] r_res_start;

    logic             r_m_valid;
    logic [1:0]       r_m_status;
    logic [LEN_W-1:0] r_m_start;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_seg             ram_wdata;
    logic [SEG_W-1:0] ram_q;
    t_seg             q;
    logic [LEN_W-1:0] w_left;
    logic             w_pf;
    logic             w_nf;

    assign q      = t_seg'(ram_q);
    assign w_left = q.len - r_size;
    assign w_pf   = (r_fidx != '0) && !r_prev.used;
    assign w_nf   = r_has_next && !r_next.used;

    bfsa_ram #(
        .DATA_W (SEG_W),
        .DEPTH  (MAX_SEG)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = r_wd;
        unique case (r_state)
            S_INIT: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = '0;
                ram_wdata.len   = r_total;
            end
            S_SHUP: begin
                ram_we    = r_pv;
                ram_waddr = r_pidx + IDX_W'(1);
                ram_wdata = q;
            end
            S_WR1: begin
                ram_we          = 1'b1;
                ram_waddr       = r_bidx;
                ram_wdata.start = r_bstart;
                ram_wdata.len   = r_size;
                ram_wdata.used  = 1'b1;
                ram_wdata.owner = r_owner;
            end
            S_WR2: begin
                ram_we          = 1'b1;
                ram_waddr       = r_bidx + IDX_W'(1);
                ram_wdata.start = r_bstart + r_size;
                ram_wdata.len   = r_bleft;
                ram_wdata.used  = 1'b0;
                ram_wdata.owner = '0;
            end
            S_RWR: begin
                ram_we = 1'b1;
            end
            S_SHDN: begin
                ram_we    = r_pv;
                ram_waddr = r_pidx - IDX_W'(r_k);
                ram_wdata = q;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_start, r_m_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_total   <= TOTAL_RST;
            r_count   <= CNT_W'(1);
            r_m_valid <= 1'b0;
            r_pv      <= 1'b0;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
            r_state <= S_INIT;
            r_pv    <= 1'b0;
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end else begin
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_count <= CNT_W'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_func     <= s_axis_tuser;
                        r_owner    <= s_axis_tdata[OWN_W-1:0];
                        r_size     <= s_axis_tdata[OWN_W +: LEN_W];
                        r_ptr      <= '0;
                        r_pv       <= 1'b0;
                        r_fnd      <= 1'b0;
                        r_nxt_pend <= 1'b0;
                        r_has_next <= 1'b0;
                        r_bv       <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        r_last <= q;
                        if (r_nxt_pend) begin
                            r_next     <= q;
                            r_has_next <= 1'b1;
                            r_nxt_pend <= 1'b0;
                        end
                        if (q.used && q.owner == r_owner && !r_fnd) begin
                            r_fnd      <= 1'b1;
                            r_fidx     <= r_pidx;
                            r_fent     <= q;
                            r_prev     <= r_last;
                            r_nxt_pend <= 1'b1;
                        end
                        if (!q.used && q.len >= r_size && (!r_bv || w_left < r_bleft)) begin
                            r_bv     <= 1'b1;
                            r_bidx   <= r_pidx;
                            r_bleft  <= w_left;
                            r_bstart <= q.start;
                        end
                    end
                    if (r_ptr < r_count) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_res_status <= ST_OK;
                    r_res_start  <= '0;
                    r_pv         <= 1'b0;
                    if (r_func == FN_ALLOC) begin
                        if (r_fnd) begin
                            r_res_status <= ST_OWNER;
                            r_state      <= S_DONE;
                        end else if (r_size == '0 || !r_bv) begin
                            r_res_status <= ST_NOFIT;
                            r_state      <= S_DONE;
                        end else if (r_bleft != '0 && r_count >= CNT_W'(MAX_SEG)) begin
                            r_res_status <= ST_NOFIT;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_start <= r_bstart;
                            r_split     <= (r_bleft != '0);
                            r_ptr       <= r_count - CNT_W'(1);
                            r_state     <= (r_bleft != '0) ? S_SHUP : S_WR1;
                        end
                    end else begin
                        if (!r_fnd) begin
                            r_res_status <= ST_OWNER;
                            r_state      <= S_DONE;
                        end else begin
                            r_wd.used  <= 1'b0;
                            r_wd.owner <= '0;
                            if (w_pf && w_nf) begin
                                r_wa       <= r_fidx - IDX_W'(1);
                                r_wd.start <= r_prev.start;
                                r_wd.len   <= r_prev.len + r_fent.len + r_next.len;
                                r_ptr      <= CNT_W'(r_fidx) + CNT_W'(2);
                                r_k        <= 2'd2;
                            end else if (w_pf) begin
                                r_wa       <= r_fidx - IDX_W'(1);
                                r_wd.start <= r_prev.start;
                                r_wd.len   <= r_prev.len + r_fent.len;
                                r_ptr      <= CNT_W'(r_fidx) + CNT_W'(1);
                                r_k        <= 2'd1;
                            end else if (w_nf) begin
                                r_wa       <= r_fidx;
                                r_wd.start <= r_fent.start;
                                r_wd.len   <= r_fent.len + r_next.len;
                                r_ptr      <= CNT_W'(r_fidx) + CNT_W'(2);
                                r_k        <= 2'd1;
                            end else begin
                                r_wa       <= r_fidx;
                                r_wd.start <= r_fent.start;
                                r_wd.len   <= r_fent.len;
                                r_ptr      <= r_count;
                                r_k        <= 2'd0;
                            end
                            r_state <= S_RWR;
                        end
                    end
                end
                S_SHUP: begin
                    // move entries above the split point up by one, top first
                    if (r_ptr > CNT_W'(r_bidx)) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr - CNT_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_state <= S_WR1;
                        end
                    end
                end
                S_WR1: begin
                    r_state <= r_split ? S_WR2 : S_DONE;
                end
                S_WR2: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_RWR: begin
                    r_state <= S_SHDN;
                end
                S_SHDN: begin
                    // close the gap left by merged entries, bottom first
                    if (r_ptr < r_count) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_count <= r_count - CNT_W'(r_k);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_start  <= r_res_start;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

endmodule

>>> verif/best_fit_segment_allocator_test.sv
// Testbench for the best-fit segment allocator: directed table plus random traffic.
`timescale 1ns / 100ps

module best_fit_segment_allocator_test;
    import bfsa_pkg::*;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [1:0]       status;
    } t_result;

    typedef struct {
        logic             func;
        logic [OWN_W-1:0] owner;
        logic [LEN_W-1:0] size;
        bit               typed;
        logic [1:0]       status;
        logic [LEN_W-1:0] start;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    best_fit_segment_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator shadow
    logic [LEN_W-1:0] tbl_start [MAX_SEG];
    logic [LEN_W-1:0] tbl_len   [MAX_SEG];
    bit               tbl_used  [MAX_SEG];
    logic [OWN_W-1:0] tbl_owner [MAX_SEG];
    int               tbl_count;

    t_result pending_results[$];
    int errors = 0, mismatches = 0, results_seen = 0, items_sent = 0;
    int ok_allocs = 0, ok_releases = 0, owner_errs = 0, nofit_errs = 0;
    bit rx_holdoff = 1'b0, rx_quiet = 1'b0, tx_quiet = 1'b0;
    int idle_cycles = 0;

    function automatic void table_reset(logic [LEN_W-1:0] size);
        for (int k = 0; k < MAX_SEG; k++) begin
            tbl_start[k] = '0; tbl_len[k] = '0; tbl_used[k] = 0; tbl_owner[k] = '0;
        end
        tbl_len[0] = size;
        tbl_count = 1;
    endfunction

    function automatic int owner_slot(logic [OWN_W-1:0] owner);
        for (int k = 0; k < tbl_count; k++)
            if (tbl_used[k] && tbl_owner[k] == owner) return k;
        return tbl_count;
    endfunction

    function automatic void drop_slot(int idx);
        for (int k = idx; k < tbl_count - 1; k++) begin
            tbl_start[k] = tbl_start[k+1]; tbl_len[k] = tbl_len[k+1];
            tbl_used[k] = tbl_used[k+1]; tbl_owner[k] = tbl_owner[k+1];
        end
        tbl_count--;
    endfunction

    function automatic t_result allocator_step(logic func, logic [OWN_W-1:0] owner,
                                               logic [LEN_W-1:0] size);
        t_result r;
        int best, idx;
        int unsigned best_left, left;
        r.status = ST_OK;
        r.start = '0;
        idx = owner_slot(owner);
        if (func == FN_ALLOC) begin
            if (idx < tbl_count) begin
                r.status = ST_OWNER;
                return r;
            end
            if (size == 0) begin
                r.status = ST_NOFIT;
                return r;
            end
            best = tbl_count;
            best_left = 0;
            for (int k = 0; k < tbl_count; k++) begin
                if (!tbl_used[k] && tbl_len[k] >= size) begin
                    left = tbl_len[k] - size;
                    if (best == tbl_count || left < best_left) begin
                        best = k; best_left = left;
                    end
                end
            end
            if (best == tbl_count || (best_left != 0 && tbl_count >= MAX_SEG)) begin
                r.status = ST_NOFIT;
                return r;
            end
            if (best_left != 0) begin
                for (int k = tbl_count; k > best; k--) begin
                    tbl_start[k] = tbl_start[k-1]; tbl_len[k] = tbl_len[k-1];
                    tbl_used[k] = tbl_used[k-1]; tbl_owner[k] = tbl_owner[k-1];
                end
                tbl_count++;
                tbl_len[best] = size;
                tbl_start[best+1] = tbl_start[best] + size;
                tbl_len[best+1] = best_left[LEN_W-1:0];
            end
            tbl_used[best] = 1;
            tbl_owner[best] = owner;
            r.start = tbl_start[best];
        end else begin
            if (idx >= tbl_count) begin
                r.status = ST_OWNER;
                return r;
            end
            tbl_used[idx] = 0;
            tbl_owner[idx] = '0;
            if (idx + 1 < tbl_count && !tbl_used[idx+1]) begin
                tbl_len[idx] = tbl_len[idx] + tbl_len[idx+1];
                drop_slot(idx + 1);
            end
            if (idx > 0 && !tbl_used[idx-1]) begin
                tbl_len[idx-1] = tbl_len[idx-1] + tbl_len[idx];
                drop_slot(idx);
            end
        end
        return r;
    endfunction

    task automatic send_request(logic func, logic [OWN_W-1:0] owner, logic [LEN_W-1:0] size,
                                bit typed = 0, logic [1:0] st = '0,
                                logic [LEN_W-1:0] st_addr = '0);
        t_result exp_r;
        if (!tx_quiet && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (!tx_quiet && $urandom_range(99) < 6);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {size, owner};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_r = allocator_step(func, owner, size);
        if (typed && (exp_r.status !== st || exp_r.start !== st_addr)) begin
            errors++;
            $display("table row mismatch: func %0d owner %0d size %0d", func, owner, size);
        end
        pending_results.push_back(exp_r);
        items_sent++;
        case (exp_r.status)
            ST_OK:    if (func == FN_ALLOC) ok_allocs++; else ok_releases++;
            ST_OWNER: owner_errs++;
            default:  nofit_errs++;
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_size(logic [LEN_W-1:0] size);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_reset(size);
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[17:0];
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("unexpected result: status %0d start %0d", got.status, got.start);
            end else begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status || got.start !== exp_r.start
                        || m_axis_tdata[OUT_DATA_W-1:18] !== '0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d start %0d, got %0d %0d",
                                 exp_r.status, exp_r.start, got.status, got.start);
                end
            end
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (rx_holdoff) m_axis_tready <= 1'b0;
        else if (rx_quiet) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(99) >= 6);
    end

    // watchdog on stalled handshakes
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rx_holdoff)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("** best_fit_segment_allocator: FAILED **");
            $finish;
        end
    end

    t_row rows[$];

    task automatic add_row(logic f, logic [OWN_W-1:0] o, logic [LEN_W-1:0] s,
                           bit t = 0, logic [1:0] st = '0, logic [LEN_W-1:0] a = '0);
        t_row r;
        r.func = f; r.owner = o; r.size = s; r.typed = t; r.status = st; r.start = a;
        rows.push_back(r);
    endtask

    initial begin
        int phase_sizes[5];
        table_reset(TOTAL_RST);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        add_row(FN_ALLOC,   8'd1,   16'd100,   1, ST_OK,    16'd0);
        add_row(FN_ALLOC,   8'd1,   16'd5,     1, ST_OWNER, 16'd0);
        add_row(FN_ALLOC,   8'd2,   16'd0,     1, ST_NOFIT, 16'd0);
        add_row(FN_ALLOC,   8'd255, 16'hFFFF,  1, ST_NOFIT, 16'd0);
        add_row(FN_ALLOC,   8'd0,   16'd200,   1, ST_OK,    16'd100);
        add_row(FN_ALLOC,   8'd255, 16'd50,    1, ST_OK,    16'd300);
        add_row(FN_RELEASE, 8'd7,   16'hFFFF,  1, ST_OWNER, 16'd0);
        add_row(FN_RELEASE, 8'd1,   16'd0,     1, ST_OK,    16'd0);
        add_row(FN_ALLOC,   8'd3,   16'd90);
        add_row(FN_RELEASE, 8'd255, 16'd0);
        add_row(FN_RELEASE, 8'd0,   16'hAAAA);
        add_row(FN_RELEASE, 8'd3,   16'h5555);
        add_row(FN_ALLOC,   8'hAA,  16'd1024,  1, ST_OK,    16'd0);
        add_row(FN_ALLOC,   8'h55,  16'd1,     1, ST_NOFIT, 16'd0);
        add_row(FN_RELEASE, 8'hAA,  16'd0,     1, ST_OK,    16'd0);
        foreach (rows[k])
            send_request(rows[k].func, rows[k].owner, rows[k].size,
                         rows[k].typed, rows[k].status, rows[k].start);

        // zero space, then one unit, then full range
        write_size(16'd0);
        send_request(FN_ALLOC, 8'd9, 16'd1, 1, ST_NOFIT, 16'd0);
        write_size(16'd1);
        send_request(FN_ALLOC, 8'd9, 16'd1, 1, ST_OK, 16'd0);
        send_request(FN_ALLOC, 8'd8, 16'd1, 1, ST_NOFIT, 16'd0);
        write_size(16'hFFFF);
        send_request(FN_ALLOC, 8'd4, 16'hFFFF, 1, ST_OK, 16'd0);
        send_request(FN_RELEASE, 8'd4, 16'd0, 1, ST_OK, 16'd0);

        // table full: 70 one-unit slices in a 200-unit space
        write_size(16'd200);
        for (int k = 0; k < 70; k++) send_request(FN_ALLOC, k[7:0], 16'd1);
        for (int k = 0; k < 70; k += 2) send_request(FN_RELEASE, k[7:0], 16'd0);

        // random phases; mostly small sizes, owners from a narrow pool to hit repeats
        phase_sizes = '{1024, 300, 65535, 64, 4000};
        foreach (phase_sizes[p]) begin
            write_size(phase_sizes[p][LEN_W-1:0]);
            rx_quiet = (p == 1);
            tx_quiet = (p == 1);
            for (int k = 0; k < 100; k++) begin
                logic [OWN_W-1:0] own;
                logic [LEN_W-1:0] sz;
                own = ($urandom_range(9) == 0) ? OWN_W'($urandom) : OWN_W'($urandom_range(40));
                case ($urandom_range(9))
                    0:       sz = LEN_W'($urandom);
                    1:       sz = LEN_W'(phase_sizes[p] >> $urandom_range(3));
                    default: sz = LEN_W'($urandom_range(1, 1 + phase_sizes[p] / 20));
                endcase
                if (p == 2 && k == 40) begin
                    // long receiver hold-off while requests keep coming
                    fork
                        begin
                            rx_holdoff = 1;
                            repeat (3000) @(posedge i_clk);
                            rx_holdoff = 0;
                        end
                    join_none
                end
                if (p == 3 && k == 60) wait_drained();
                send_request(logic'($urandom_range(99) < 45), own, sz);
            end
        end
        rx_quiet = 0;
        tx_quiet = 0;

        wait_drained();
        $display("%0d requests, %0d results: %0d allocs ok, %0d releases ok,",
                 items_sent, results_seen, ok_allocs, ok_releases);
        $display("%0d owner rejects, %0d no-fit rejects, table sizes from 0 to 65535",
                 owner_errs, nofit_errs);
        if (errors == 0 && pending_results.size() == 0)
            $display("** best_fit_segment_allocator: PASSED **");
        else
            $display("** best_fit_segment_allocator: FAILED **");
        $finish;
    end

endmodule
